/* hw/rtl/swrc_pkg.sv */
// ----------------------------------------------------------------------------
// swrc_pkg
// Types and constants shared by the sliding window request counter.
// ----------------------------------------------------------------------------
package swrc_pkg;

   localparam int NUM_BUCKETS_DEF  = 60;
   localparam int WINDOW_MAX_DEF   = 60;
   localparam int COUNT_WIDTH_DEF  = 32;

   localparam int OUT_W = 38;
   localparam int WIN_W = 6;

   typedef enum logic [1:0] {
      FUNC_RECORD = 2'd0,
      FUNC_TICK   = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef struct packed {
      func_type           func;
      logic               is_reject;
      logic [WIN_W-1:0]   win_len;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]   total_count;
      logic [OUT_W-1:0]   reject_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_REC_WR,
      ST_Q_RD,
      ST_Q_LAST,
      ST_Q_OUT
   } state_type;

endpackage

/* hw/rtl/swrc_sat_add.sv */
// ----------------------------------------------------------------------------
// swrc_sat_add
// Shared two-lane saturating adder for bucket increments and window sums.
// ----------------------------------------------------------------------------
module swrc_sat_add
   import swrc_pkg::*;
#(
   parameter int DW = OUT_W
) (
   input  logic [DW-1:0] a_total,
   input  logic [DW-1:0] b_total,
   input  logic [DW-1:0] a_reject,
   input  logic [DW-1:0] b_reject,
   input  logic [DW-1:0] limit,
   output logic [DW-1:0] sum_total,
   output logic [DW-1:0] sum_reject
);

   logic [DW:0] raw_total;
   logic [DW:0] raw_reject;

   always_comb begin
      raw_total  = {1'b0, a_total} + {1'b0, b_total};
      raw_reject = {1'b0, a_reject} + {1'b0, b_reject};
      sum_total  = (raw_total > {1'b0, limit}) ? limit : raw_total[DW-1:0];
      sum_reject = (raw_reject > {1'b0, limit}) ? limit : raw_reject[DW-1:0];
   end

endmodule

/* hw/rtl/sliding_window_request_counter_unit.sv */
// ----------------------------------------------------------------------------
// sliding_window_request_counter_unit
// Ring of per-second buckets with total and reject counts, windowed sums.
// ----------------------------------------------------------------------------
// Words enter on req_valid/req_stall as req_type: record, tick, query, clear.
// Only a query returns a word on rsp_valid/rsp_stall: the saturated sums of
// totals and rejects over the newest N buckets, N clamped to 1..min(WINDOW_MAX, NUM_BUCKETS).
// Buckets live in one memory with one write and one registered read port;
// a single saturating adder serves both record increments and query sums.
// Steps per word, set by the registered memory read port and the bucket walk:
//   tick   zero the next bucket and advance the current slot
//   record read, then write back the incremented bucket
//   query  one bucket read per cycle, drain, result load
//   clear  one bucket zeroed per cycle
// After reset the block sweeps all NUM_BUCKETS buckets to zero, holding
// req_stall high during the sweep, and the current slot is zero.
// The result register holds a query result while rsp_stall is high; new
// words are still taken, and a later query waits in its last step until
// the result register is free.
// ----------------------------------------------------------------------------
module sliding_window_request_counter_unit
   import swrc_pkg::*;
#(
   parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
   parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int SLOT_W  = $clog2(NUM_BUCKETS);
   localparam int WIN_LIM = (WINDOW_MAX < NUM_BUCKETS) ? WINDOW_MAX : NUM_BUCKETS;
   localparam int WW_RAW  = $clog2(WIN_LIM + 1);
   localparam int WW      = (WW_RAW > WIN_W) ? WW_RAW : WIN_W;
   localparam int DW      = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_BUCKETS - 1);
   localparam logic [WW-1:0]     WIN_TOP   = WW'(WIN_LIM);
   localparam logic [DW-1:0]     COUNT_MAX = DW'({COUNT_WIDTH{1'b1}});
   localparam logic [DW-1:0]     OUT_MAX   = DW'({OUT_W{1'b1}});

   state_type state_ff, state_in;

   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_W-1:0]      sweep_ff, sweep_in;
   logic [SLOT_W-1:0]      qaddr_ff, qaddr_in;
   logic [WW-1:0]          rem_ff, rem_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   rej_ff, rej_in;
   logic [OUT_W-1:0]       acc_t_ff, acc_t_in;
   logic [OUT_W-1:0]       acc_r_ff, acc_r_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [2*COUNT_WIDTH-1:0] mem [NUM_BUCKETS];
   logic [2*COUNT_WIDTH-1:0] rd_data_ff;

   logic                     mem_we;
   logic [SLOT_W-1:0]        mem_wa;
   logic [2*COUNT_WIDTH-1:0] mem_wd;
   logic                     mem_re;
   logic [SLOT_W-1:0]        mem_ra;

   logic                   accept;
   logic                   rsp_free;
   logic [SLOT_W-1:0]      slot_next;
   logic [SLOT_W-1:0]      qaddr_prev;
   logic [WW-1:0]          win_ext;
   logic [WW-1:0]          win_eff;
   logic [COUNT_WIDTH-1:0] rd_total;
   logic [COUNT_WIDTH-1:0] rd_reject;

   logic [DW-1:0] add_a_t, add_b_t, add_a_r, add_b_r, add_lim;
   logic [DW-1:0] add_s_t, add_s_r;

   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rd_total  = rd_data_ff[2*COUNT_WIDTH-1:COUNT_WIDTH];
   assign rd_reject = rd_data_ff[COUNT_WIDTH-1:0];

   always_comb begin
      slot_next  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
      qaddr_prev = (qaddr_ff == '0) ? SLOT_LAST : qaddr_ff - 1'b1;
      win_ext    = WW'(req_data.win_len);
      if (win_ext > WIN_TOP) begin
         win_eff = WIN_TOP;
      end else if (win_ext == '0) begin
         win_eff = WW'(1);
      end else begin
         win_eff = win_ext;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (sweep_ff == SLOT_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.func)
                  FUNC_RECORD: state_in = ST_REC_WR;
                  FUNC_QUERY:  state_in = ST_Q_RD;
                  FUNC_CLEAR:  state_in = ST_SWEEP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_REC_WR: state_in = ST_IDLE;
         ST_Q_RD: begin
            if (rem_ff == WW'(1)) state_in = ST_Q_LAST;
         end
         ST_Q_LAST: state_in = ST_Q_OUT;
         ST_Q_OUT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_SWEEP;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      mem_wa    = slot_ff;
      mem_wd    = '0;
      mem_re    = 1'b0;
      mem_ra    = slot_ff;
      add_a_t   = DW'(acc_t_ff);
      add_b_t   = DW'(rd_total);
      add_a_r   = DW'(acc_r_ff);
      add_b_r   = DW'(rd_reject);
      add_lim   = OUT_MAX;
      case (state_ff)
         ST_SWEEP: begin
            mem_we = 1'b1;
            mem_wa = sweep_ff;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (accept && req_data.func == FUNC_TICK) begin
               mem_we = 1'b1;
               mem_wa = slot_next;
            end
            if (accept && req_data.func == FUNC_RECORD) begin
               mem_re = 1'b1;
            end
         end
         ST_REC_WR: begin
            add_a_t = DW'(rd_total);
            add_b_t = DW'(1'b1);
            add_a_r = DW'(rd_reject);
            add_b_r = DW'(rej_ff);
            add_lim = COUNT_MAX;
            mem_we  = 1'b1;
            mem_wd  = {add_s_t[COUNT_WIDTH-1:0], add_s_r[COUNT_WIDTH-1:0]};
         end
         ST_Q_RD: begin
            mem_re = 1'b1;
            mem_ra = qaddr_ff;
         end
         ST_Q_LAST, ST_Q_OUT: begin
         end
         default: begin
         end
      endcase
   end

   swrc_sat_add #(
      .DW(DW)
   ) u_add (
      .a_total   (add_a_t),
      .b_total   (add_b_t),
      .a_reject  (add_a_r),
      .b_reject  (add_b_r),
      .limit     (add_lim),
      .sum_total (add_s_t),
      .sum_reject(add_s_r)
   );

   // datapath next values
   always_comb begin
      slot_in      = slot_ff;
      sweep_in     = sweep_ff;
      qaddr_in     = qaddr_ff;
      rem_in       = rem_ff;
      rej_in       = rej_ff;
      acc_t_in     = acc_t_ff;
      acc_r_in     = acc_r_ff;
      rd_vld_in    = (state_ff == ST_Q_RD);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_SWEEP) begin
         sweep_in = sweep_ff + 1'b1;
      end
      if (accept) begin
         case (req_data.func)
            FUNC_RECORD: rej_in = req_data.is_reject;
            FUNC_TICK:   slot_in = slot_next;
            FUNC_QUERY: begin
               qaddr_in = slot_ff;
               rem_in   = win_eff;
               acc_t_in = '0;
               acc_r_in = '0;
            end
            FUNC_CLEAR:  sweep_in = '0;
            default: begin
            end
         endcase
      end
      if (state_ff == ST_Q_RD) begin
         qaddr_in = qaddr_prev;
         rem_in   = rem_ff - 1'b1;
      end
      if (rd_vld_ff) begin
         acc_t_in = add_s_t[OUT_W-1:0];
         acc_r_in = add_s_r[OUT_W-1:0];
      end
      if (state_ff == ST_Q_OUT && rsp_free) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.total_count  = acc_t_ff;
         rsp_data_in.reject_count = acc_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         slot_ff      <= '0;
         sweep_ff     <= '0;
         rem_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         sweep_ff     <= sweep_in;
         rem_ff       <= rem_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qaddr_ff    <= qaddr_in;
      rej_ff      <= rej_in;
      acc_t_ff    <= acc_t_in;
      acc_r_ff    <= acc_r_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

endmodule

/* hw/rtl/swrc_checker.sv */
// ----------------------------------------------------------------------------
// swrc_checker
// Port-level checks for the sliding window request counter.
// ----------------------------------------------------------------------------
module swrc_checker
   import swrc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("ready during bucket sweep");

   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.func != FUNC_TICK |=> req_stall)
      else $error("multi-cycle word did not hold off input");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a query in progress");

endmodule

bind sliding_window_request_counter_unit swrc_checker u_swrc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

/* dv/sliding_window_request_counter_unit_tb.sv */
// ----------------------------------------------------------------------------
// sliding_window_request_counter_unit_tb
// Self-checking testbench for the sliding window request counter.
// ----------------------------------------------------------------------------
// A queue of request words feeds a clocked driver. Each accepted word updates
// a local model of the bucket ring, and each query adds its expected window
// sums to a queue. A clocked monitor compares every response word against
// the oldest entry in that queue. Both sides idle at random. The receiver
// holds off for a long stretch so that the block backs up. The sender waits
// at times until every pending sum has returned. Long record bursts pile
// up counts in a single bucket.
// ----------------------------------------------------------------------------
module sliding_window_request_counter_unit_tb;
   import swrc_pkg::*;

   localparam int BUCKETS      = NUM_BUCKETS_DEF;
   localparam int WIN_MAX      = WINDOW_MAX_DEF;
   localparam int COUNT_W      = COUNT_WIDTH_DEF;
   localparam int RANDOM_WORDS = 2000;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 2 * BUCKETS + 10;
   localparam int HOLD_CYCLES  = 400;

   localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};
   localparam logic [63:0]        SUM_MAX = (64'd1 << OUT_W) - 64'd1;

   typedef struct {
      req_type word;
      int      gap;
      bit      drain;
   } pending_word_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_word_type pending_words[$];
   rsp_type          expected_sums[$];

   logic [COUNT_W-1:0] total_bk  [BUCKETS];
   logic [COUNT_W-1:0] reject_bk [BUCKETS];
   int                 cur_slot;

   int  fail_count   = 0;
   int  cycle_count  = 0;
   int  gap_left     = 0;
   bit  no_idle      = 1'b0;
   int  stall_left   = 0;
   int  hold_left    = 0;
   int  mode_left    = 0;
   bit  rx_quiet     = 1'b0;
   int  results_seen = 0;

   sliding_window_request_counter_unit #(
      .NUM_BUCKETS  (BUCKETS),
      .WINDOW_MAX   (WIN_MAX),
      .COUNT_WIDTH  (COUNT_W)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic apply_word(input req_type w);
      int          n;
      int          idx;
      logic [63:0] tsum;
      logic [63:0] rsum;
      rsp_type     r;
      case (w.func)
         FUNC_RECORD: begin
            if (total_bk[cur_slot] != CNT_MAX) total_bk[cur_slot] = total_bk[cur_slot] + 1'b1;
            if (w.is_reject && reject_bk[cur_slot] != CNT_MAX) begin
               reject_bk[cur_slot] = reject_bk[cur_slot] + 1'b1;
            end
         end
         FUNC_TICK: begin
            cur_slot = (cur_slot + 1) % BUCKETS;
            total_bk[cur_slot]  = '0;
            reject_bk[cur_slot] = '0;
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < BUCKETS; i++) begin
               total_bk[i]  = '0;
               reject_bk[i] = '0;
            end
         end
         FUNC_QUERY: begin
            n = int'(w.win_len);
            if (n > WIN_MAX) n = WIN_MAX;
            if (n > BUCKETS) n = BUCKETS;
            if (n == 0) n = 1;
            tsum = '0;
            rsum = '0;
            for (int i = 0; i < n; i++) begin
               idx  = (cur_slot + BUCKETS - i) % BUCKETS;
               tsum = tsum + 64'(total_bk[idx]);
               rsum = rsum + 64'(reject_bk[idx]);
            end
            if (tsum > SUM_MAX) tsum = SUM_MAX;
            if (rsum > SUM_MAX) rsum = SUM_MAX;
            r.total_count  = tsum[OUT_W-1:0];
            r.reject_count = rsum[OUT_W-1:0];
            expected_sums.push_back(r);
         end
         default: begin
         end
      endcase
   endtask

   task automatic add_word(input func_type f, input logic rej, input logic [WIN_W-1:0] win,
                           input bit drain);
      pending_word_type p;
      p.word.func       = f;
      p.word.is_reject  = rej;
      p.word.win_len    = win;
      p.gap             = no_idle ? 0 : $urandom_range(0, 3);
      p.drain           = drain;
      pending_words.push_back(p);
   endtask

   task automatic add_burst();
      int len;
      len = $urandom_range(256, 300);
      for (int i = 0; i < len; i++) begin
         add_word(FUNC_RECORD, ($urandom_range(0, 9) != 0), WIN_W'($urandom), 1'b0);
      end
      add_word(FUNC_QUERY, 1'($urandom), '0, 1'b0);
      add_word(FUNC_QUERY, 1'($urandom), WIN_W'($urandom), 1'b0);
   endtask

   task automatic add_segment();
      int       len;
      int       pick;
      func_type f;
      len = $urandom_range(10, 40);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) f = FUNC_RECORD;
         else if (pick < 80) f = FUNC_TICK;
         else if (pick < 97) f = FUNC_QUERY;
         else f = FUNC_CLEAR;
         add_word(f, 1'($urandom), WIN_W'($urandom), ($urandom_range(0, 99) == 0));
      end
   endtask

   always @(posedge clock) begin : drive
      pending_word_type p;
      bit               accepted;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         gap_left  = 0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) apply_word(req_data);
         if (req_valid && !accepted) begin
            // hold the offered word
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0 &&
                      !(pending_words[0].drain && expected_sums.size() != 0)) begin
            p = pending_words.pop_front();
            req_valid <= 1'b1;
            req_data  <= p.word;
            gap_left  = p.gap;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : collect
      rsp_type exp_w;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_sums.size() == 0) begin
               $display("%0t: unexpected response word: total %0d, reject %0d",
                        $time, rsp_data.total_count, rsp_data.reject_count);
               fail_count++;
            end else begin
               exp_w = expected_sums.pop_front();
               if (rsp_data.total_count !== exp_w.total_count) begin
                  $display("%0t: total_count mismatch: expected %0d, actual %0d",
                           $time, exp_w.total_count, rsp_data.total_count);
                  fail_count++;
               end
               if (rsp_data.reject_count !== exp_w.reject_count) begin
                  $display("%0t: reject_count mismatch: expected %0d, actual %0d",
                           $time, exp_w.reject_count, rsp_data.reject_count);
                  fail_count++;
               end
            end
            stall_left = rx_quiet ? 0 : $urandom_range(0, 3);
            if (results_seen == 20 || results_seen == 150) hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            rx_quiet  = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int random_start;
      for (int i = 0; i < BUCKETS; i++) begin
         total_bk[i]  = '0;
         reject_bk[i] = '0;
      end
      cur_slot = 0;

      add_word(FUNC_RECORD, 1'b0, '1, 1'b0);
      add_word(FUNC_RECORD, 1'b1, '0, 1'b0);
      add_word(FUNC_QUERY,  1'b0, '0, 1'b0);
      add_word(FUNC_QUERY,  1'b0, WIN_W'(1), 1'b0);
      add_word(FUNC_QUERY,  1'b1, '1, 1'b0);
      add_word(FUNC_QUERY,  1'b0, WIN_W'(WIN_MAX), 1'b0);
      add_word(FUNC_QUERY,  1'b0, WIN_W'(WIN_MAX - 1), 1'b0);
      add_word(FUNC_TICK,   1'b1, '1, 1'b0);
      add_word(FUNC_RECORD, 1'b1, WIN_W'(21), 1'b0);
      add_word(FUNC_RECORD, 1'b0, WIN_W'(42), 1'b0);
      add_word(FUNC_QUERY,  1'b0, WIN_W'(2), 1'b0);
      add_word(FUNC_QUERY,  1'b1, WIN_W'(WIN_MAX + 1), 1'b0);
      add_word(FUNC_CLEAR,  1'b1, '1, 1'b0);
      add_word(FUNC_QUERY,  1'b0, '1, 1'b0);
      add_word(FUNC_TICK,   1'b0, '0, 1'b0);
      add_word(FUNC_RECORD, 1'b1, '0, 1'b0);
      add_word(FUNC_QUERY,  1'b0, '0, 1'b1);
      add_word(FUNC_CLEAR,  1'b0, '0, 1'b0);
      add_word(FUNC_QUERY,  1'b0, WIN_W'(WIN_MAX), 1'b0);

      random_start = pending_words.size();
      add_burst();
      while (pending_words.size() - random_start < RANDOM_WORDS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 19) == 0) add_burst();
         else add_segment();
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
